>>> hdl/usb_charger_detect_sequencer_core_assert.svh
// Assertion macros shared by the charger detect checker.
`ifndef USB_CHARGER_DETECT_SEQUENCER_CORE_ASSERT_SVH
`define USB_CHARGER_DETECT_SEQUENCER_CORE_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define UCDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property only while the output channel holds a word.
`define UCDS_ASSERT_OUT(label, prop, msg) \
  `UCDS_ASSERT(label, m_axis_tvalid |-> (prop), msg)

`endif

>>> hdl/ucds_pkg.sv
// Types and constants for the USB charger detect sequencer.
package ucds_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned IN_W       = 8;
  localparam int unsigned OUT_W      = 8;
  localparam int unsigned CLASS_W    = 3;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [CFG_W-1:0] CONTACT_TIMEOUT_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] SETTLE_RST          = CFG_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE          = 1'b1;

  typedef enum logic [5:0] {
    PH_WAIT_VBUS = 6'b000001,
    PH_CONTACT   = 6'b000010,
    PH_SETTLE    = 6'b000100,
    PH_PRIMARY   = 6'b001000,
    PH_SECONDARY = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE        = 3'd0,
    CLS_NONSTANDARD = 3'd1,
    CLS_STANDARD    = 3'd2,
    CLS_CHARGING    = 3'd3,
    CLS_DEDICATED   = 3'd4
  } class_e;

  typedef struct packed {
    logic vbus_present;
    logic contact_detected;
    logic primary_detected;
    logic secondary_detected;
    logic ms_tick;
  } sample_t;

  typedef struct packed {
    logic   contact_enable;
    logic   primary_enable;
    logic   secondary_enable;
    logic   detect_mode;
    class_e port_class;
    logic   link_ready;
  } result_t;

endpackage

>>> hdl/ucds_seq.sv
// Detection phase sequencer with millisecond timer; one step per accepted sample.
module ucds_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  ucds_pkg::sample_t       sample_i,
  input  logic [ucds_pkg::CFG_W-1:0] contact_timeout_i,
  input  logic [ucds_pkg::CFG_W-1:0] settle_i,
  output ucds_pkg::result_t       result_o
);
  import ucds_pkg::*;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  class_e                class_q, class_d;
  logic                  fresh, saturated, timeout_over, settle_over;

  always_comb begin
    fresh = phase_q inside {PH_WAIT_VBUS, PH_DONE};
    // advance once per tick while a timed phase runs, stick at full scale
    cnt_inc = cnt_q;
    if (!fresh && sample_i.ms_tick && cnt_q != TIMER_MAX) begin
      cnt_inc = cnt_q + TIMER_BITS'(1);
    end
    saturated    = (cnt_inc == TIMER_MAX);
    timeout_over = (cnt_inc >= contact_timeout_i) || saturated;
    settle_over  = (cnt_inc >= settle_i) || saturated;

    phase_d = phase_q;
    cnt_d   = cnt_inc;
    class_d = class_q;
    case (phase_q)
      PH_WAIT_VBUS: begin
        class_d = CLS_NONE;
        if (sample_i.vbus_present) begin
          phase_d = PH_CONTACT;
          cnt_d   = '0;
        end
      end
      PH_CONTACT: begin
        // timeout wins over a contact seen on the same sample
        if (timeout_over) begin
          class_d = CLS_NONSTANDARD;
          phase_d = PH_DONE;
          cnt_d   = '0;
        end else if (sample_i.contact_detected) begin
          phase_d = PH_SETTLE;
          cnt_d   = '0;
        end
      end
      PH_SETTLE: begin
        if (settle_over) begin
          phase_d = PH_PRIMARY;
          cnt_d   = '0;
        end
      end
      PH_PRIMARY: begin
        if (settle_over) begin
          cnt_d = '0;
          if (sample_i.primary_detected) begin
            phase_d = PH_SECONDARY;
          end else if (sample_i.vbus_present) begin
            class_d = CLS_STANDARD;
            phase_d = PH_DONE;
          end else begin
            class_d = CLS_NONE;
            phase_d = PH_WAIT_VBUS;
          end
        end
      end
      PH_SECONDARY: begin
        if (settle_over) begin
          cnt_d = '0;
          if (!sample_i.vbus_present) begin
            class_d = CLS_NONE;
            phase_d = PH_WAIT_VBUS;
          end else begin
            class_d = sample_i.secondary_detected ? CLS_DEDICATED : CLS_CHARGING;
            phase_d = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        cnt_d = '0;
      end
      default: begin
        phase_d = PH_DONE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_VBUS;
      cnt_q   <= '0;
      class_q <= CLS_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      class_q <= class_d;
    end
  end

  // result reflects the state after this sample
  always_comb begin
    result_o.contact_enable   = (phase_d == PH_CONTACT) || (phase_d == PH_SETTLE);
    result_o.primary_enable   = (phase_d == PH_PRIMARY);
    result_o.secondary_enable = (phase_d == PH_SECONDARY);
    result_o.detect_mode      = phase_d inside {PH_CONTACT, PH_SETTLE, PH_PRIMARY,
                                                PH_SECONDARY};
    result_o.port_class       = class_d;
    result_o.link_ready       = sample_i.vbus_present && (class_d != CLS_NONE);
  end

endmodule

>>> hdl/usb_charger_detect_sequencer_core.sv
// Top level of the USB charger detect sequencer: config registers, stream handshake, result register.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: one VBUS and detector sample
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: enables, class, link ready
//  cfg     | in  | cfg_we_i (always taken)       | cfg_index_i, cfg_data_i
//
// One sample per clock while the output is not stalled: the phase and timer update in the cycle a word is taken,
// and the result lands in a single output register in the cycle after.
// A new word is taken whenever the output register is empty or drained that cycle,
// so a stalled output holds its word and stops input only while it stays full.
// Reset clears the phase to waiting for VBUS, the timer and class to zero, and
// loads the contact timeout with 1000 ms and the settle time with 100 ms.
module usb_charger_detect_sequencer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] vbus_present, [1] contact_detected, [2] primary_detected,
  // [3] secondary_detected, [4] ms_tick, [7:5] zero
  input  logic [ucds_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] contact_enable, [1] primary_enable, [2] secondary_enable,
  // [3] detect_mode, [6:4] port_class, [7] link_ready
  output logic [ucds_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ucds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ucds_pkg::CFG_W-1:0]     cfg_data_i
);
  import ucds_pkg::*;

  logic [CFG_W-1:0] contact_timeout_q, settle_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic             accept;
  sample_t          sample;
  result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_timeout_q <= CONTACT_TIMEOUT_RST;
      settle_q          <= SETTLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CONTACT_TIMEOUT: contact_timeout_q <= cfg_data_i;
        REG_SETTLE:          settle_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    sample.vbus_present       = s_axis_tdata[0];
    sample.contact_detected   = s_axis_tdata[1];
    sample.primary_detected   = s_axis_tdata[2];
    sample.secondary_detected = s_axis_tdata[3];
    sample.ms_tick            = s_axis_tdata[4];
  end

  ucds_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (accept),
    .sample_i          (sample),
    .contact_timeout_i (contact_timeout_q),
    .settle_i          (settle_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {result.link_ready, result.port_class, result.detect_mode,
                     result.secondary_enable, result.primary_enable,
                     result.contact_enable};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/ucds_checker.sv
// Port-level checks for the charger detect sequencer, bound to the top level.
`include "usb_charger_detect_sequencer_core_assert.svh"

module ucds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ucds_pkg::OUT_W-1:0] m_axis_tdata
);
  import ucds_pkg::*;

  // a stalled word holds
  `UCDS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")
  // an empty output register never blocks input
  `UCDS_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `UCDS_ASSERT_OUT(a_enables_exclusive, $onehot0(m_axis_tdata[2:0]) && (m_axis_tdata[3] == (|m_axis_tdata[2:0])), "detector enables overlap or disagree with detect mode")
  `UCDS_ASSERT_OUT(a_class_range, (m_axis_tdata[6] == 1'b0) || (m_axis_tdata[5:4] == 2'b00), "port class out of range")
  `UCDS_ASSERT_OUT(a_link_needs_class, !m_axis_tdata[7] || (m_axis_tdata[6:4] != 3'd0), "link ready without a port class")

endmodule

bind usb_charger_detect_sequencer_core ucds_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
